@@ sv/rom_prefetch_buffer_core_assert.svh @@
// Assertion macros shared by the prefetch buffer checkers.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ROM_PREFETCH_BUFFER_CORE_ASSERT_SVH
`define ROM_PREFETCH_BUFFER_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define RPB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpb assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define RPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpb assertion failed");

`endif

@@ sv/rpb_pkg.sv @@
// Package for the ROM prefetch buffer: payload structs, register codes,
// region decode constants and sizes. Depends on nothing.
package rpb_pkg;

  localparam int unsigned BufferDepth = 8;
  localparam int unsigned CdW         = 5;   // countdown: wide enough for a doubled 4-bit wait state
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned CfgRegW     = 4;

  localparam logic [CfgRegW-1:0] Ws0SeqReset = 4'd3;
  localparam logic [CfgRegW-1:0] Ws1SeqReset = 4'd5;
  localparam logic [CfgRegW-1:0] Ws2SeqReset = 4'd9;
  localparam logic [CfgRegW-1:0] SramReset   = 4'd5;

  // top address byte of each region
  localparam logic [7:0] RegionWs0Lo  = 8'h08;
  localparam logic [7:0] RegionWs0Hi  = 8'h09;
  localparam logic [7:0] RegionWs1Lo  = 8'h0A;
  localparam logic [7:0] RegionWs1Hi  = 8'h0B;
  localparam logic [7:0] RegionWs2Lo  = 8'h0C;
  localparam logic [7:0] RegionWs2Hi  = 8'h0D;
  localparam logic [7:0] RegionSramLo = 8'h0E;
  localparam logic [7:0] RegionSramHi = 8'h0F;

  localparam logic [31:0] StepThumb = 32'd2;
  localparam logic [31:0] StepArm   = 32'd4;

  typedef enum logic [CfgIdxW-1:0] {
    RegWs0Seq = 8'd0,
    RegWs1Seq = 8'd1,
    RegWs2Seq = 8'd2,
    RegSram   = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] bus_address;
    logic [7:0]  access_cycles;
    logic [31:0] program_counter;
    logic        thumb_mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ticked_cycles;
    logic       buffer_hit;
    logic       buffer_flushed;
  } out_item_t;

  function automatic logic in_rom(input logic [31:0] addr);
    return (addr[31:24] >= RegionWs0Lo) && (addr[31:24] <= RegionWs2Hi);
  endfunction

endpackage

@@ sv/rom_prefetch_buffer_core.sv @@
// A result is registered when its transaction is accepted and is shown in the next cycle.
// Throughput: one transaction per cycle while the result is not stalled; the ring, countdown and result are
// all updated in the accept cycle, so the next access sees the new state.
// Config writes are taken every cycle. Reset (rst_ni low, async) empties the
// ring, cancels any fetch and restores the wait-state register defaults.
// Top level of the ROM prefetch buffer; uses rpb_pkg.
module rom_prefetch_buffer_core #(
  parameter int unsigned BUFFER_DEPTH = rpb_pkg::BufferDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rpb_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rpb_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rpb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rpb_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned PosW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CdW  = rpb_pkg::CdW;
  localparam logic [CntW-1:0] CapThumb = CntW'(BUFFER_DEPTH);
  localparam logic [CntW-1:0] CapArm   = CntW'(BUFFER_DEPTH / 2);
  localparam logic [PosW-1:0] LastPos  = PosW'(BUFFER_DEPTH - 1);

  function automatic logic [PosW-1:0] ring_next(input logic [PosW-1:0] p);
    return (p == LastPos) ? '0 : p + PosW'(1);
  endfunction

  // config registers
  logic [rpb_pkg::CfgRegW-1:0] ws0_q, ws1_q, ws2_q, sram_q;

  // buffer state
  logic            fa_q, fa_d;
  logic [PosW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CdW-1:0]  cd_q, cd_d;
  logic [31:0]     lfa_q, lfa_d;
  logic [31:0]     lra_q, lra_d;
  logic [31:0]     entry_q [BUFFER_DEPTH];

  logic               out_valid_q;
  rpb_pkg::out_item_t out_item_q, out_item_d;

  logic            in_acc;
  logic            entry_we;
  logic [31:0]     addr, pc, next_addr, head_addr;
  logic            thumb, addr_rom;
  logic [CntW-1:0] capacity;
  logic            start_ok;
  logic [CdW-1:0]  cost;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  assign addr      = in_item_i.bus_address;
  assign pc        = in_item_i.program_counter;
  assign thumb     = in_item_i.thumb_mode;
  assign addr_rom  = rpb_pkg::in_rom(addr);
  assign capacity  = thumb ? CapThumb : CapArm;
  assign head_addr = entry_q[rd_q];
  assign next_addr = ((cnt_q != '0) ? lfa_q : pc)
                   + (thumb ? rpb_pkg::StepThumb : rpb_pkg::StepArm);
  assign start_ok  = (cnt_q < capacity) && rpb_pkg::in_rom(pc) && !addr_rom
                   && (pc == lra_q);

  // cost of the sequential fetch about to start
  always_comb begin
    unique case (next_addr[31:24])
      rpb_pkg::RegionSramLo, rpb_pkg::RegionSramHi: cost = CdW'(sram_q);
      rpb_pkg::RegionWs0Lo, rpb_pkg::RegionWs0Hi:
        cost = thumb ? CdW'(ws0_q) : CdW'({ws0_q, 1'b0});
      rpb_pkg::RegionWs1Lo, rpb_pkg::RegionWs1Hi:
        cost = thumb ? CdW'(ws1_q) : CdW'({ws1_q, 1'b0});
      rpb_pkg::RegionWs2Lo, rpb_pkg::RegionWs2Hi:
        cost = thumb ? CdW'(ws2_q) : CdW'({ws2_q, 1'b0});
      default: cost = CdW'(1);
    endcase
  end

  always_comb begin
    fa_d       = fa_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    cnt_d      = cnt_q;
    cd_d       = cd_q;
    lfa_d      = lfa_q;
    lra_d      = lra_q;
    entry_we   = 1'b0;
    out_item_d = '{ticked_cycles: in_item_i.access_cycles,
                   buffer_hit: 1'b0, buffer_flushed: 1'b0};

    if (fa_q && (addr == lfa_q)) begin
      // access lands on the in-flight fetch: wait out the rest of it
      fa_d  = 1'b0;
      cd_d  = '0;
      lra_d = addr;
      out_item_d.ticked_cycles = 8'(cd_q);
      out_item_d.buffer_hit    = 1'b1;
    end else begin
      if (fa_q) begin
        if (addr_rom) fa_d = 1'b0;   // ROM access aborts the fetch
      end else if (start_ok) begin
        fa_d     = 1'b1;
        entry_we = 1'b1;
        lfa_d    = next_addr;
        cd_d     = cost;
      end

      if (addr_rom) lra_d = addr;

      if ((cnt_q != '0) && (addr == pc)) begin
        if (addr == head_addr) begin
          out_item_d.ticked_cycles = 8'd1;
          out_item_d.buffer_hit    = 1'b1;
          cnt_d = cnt_q - CntW'(1);
          rd_d  = ring_next(rd_q);
        end else begin
          fa_d  = 1'b0;
          cd_d  = '0;
          cnt_d = '0;
          rd_d  = '0;
          wr_d  = '0;
          out_item_d.buffer_flushed = 1'b1;
        end
      end

      // charge this access against the running fetch
      if (fa_d) begin
        if (out_item_d.ticked_cycles >= 8'(cd_d)) begin
          cd_d = '0;
          if (cnt_d != CapThumb) cnt_d = cnt_d + CntW'(1);
          wr_d = ring_next(wr_d);
          fa_d = 1'b0;
        end else begin
          cd_d = cd_d - CdW'(out_item_d.ticked_cycles);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_q        <= 1'b0;
      rd_q        <= '0;
      wr_q        <= '0;
      cnt_q       <= '0;
      cd_q        <= '0;
      lra_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        fa_q  <= fa_d;
        rd_q  <= rd_d;
        wr_q  <= wr_d;
        cnt_q <= cnt_d;
        cd_q  <= cd_d;
        lra_q <= lra_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lfa_q      <= lfa_d;
      out_item_q <= out_item_d;
      if (entry_we) entry_q[wr_q] <= next_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws0_q  <= rpb_pkg::Ws0SeqReset;
      ws1_q  <= rpb_pkg::Ws1SeqReset;
      ws2_q  <= rpb_pkg::Ws2SeqReset;
      sram_q <= rpb_pkg::SramReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rpb_pkg::RegWs0Seq: ws0_q  <= cfg_data_i[rpb_pkg::CfgRegW-1:0];
        rpb_pkg::RegWs1Seq: ws1_q  <= cfg_data_i[rpb_pkg::CfgRegW-1:0];
        rpb_pkg::RegWs2Seq: ws2_q  <= cfg_data_i[rpb_pkg::CfgRegW-1:0];
        rpb_pkg::RegSram:   sram_q <= cfg_data_i[rpb_pkg::CfgRegW-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/rpb_checker.sv @@
// Port-level checker for rom_prefetch_buffer_core, bound to the top level.
// Uses rpb_pkg types and the macros of rom_prefetch_buffer_core_assert.svh.
`include "rom_prefetch_buffer_core_assert.svh"

module rpb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input rpb_pkg::out_item_t            out_item_o
);

  // stalled result holds
  `RPB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

  // every accepted transaction produces a result next cycle
  `RPB_ASSERT_NEXT(a_accept_result, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)

  // a result is never both a hit and a flush
  `RPB_ASSERT_IMPL(a_hit_xor_flush, clk_i, rst_ni, out_valid_o, !(out_item_o.buffer_hit && out_item_o.buffer_flushed))

  // a hit costs at most one full double-width fetch
  `RPB_ASSERT_IMPL(a_hit_bound, clk_i, rst_ni, out_valid_o && out_item_o.buffer_hit, out_item_o.ticked_cycles <= 8'd30)

endmodule

bind rom_prefetch_buffer_core rpb_checker u_rpb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for rom_prefetch_buffer_core: a queue-fed driver, a monitor and a
// cycle-exact predictor of the prefetch ring. Depends on rpb_pkg and the core RTL.
module tb_top;

  localparam int unsigned IdlePct    = 22;
  localparam int unsigned PtrW       = $clog2(rpb_pkg::BufferDepth);
  localparam int unsigned MaxReports = 10;
  localparam longint      TimeoutNs  = 64'd12 * 64'd200_000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  rpb_pkg::in_item_t            in_item = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  rpb_pkg::out_item_t           out_item;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [rpb_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [rpb_pkg::CfgDataW-1:0] cfg_data = '0;

  logic             in_taken = 1'b0;
  logic             calm = 1'b0;
  int unsigned      err_cnt = 0;
  int unsigned      gen_cnt = 0;

  rpb_pkg::in_item_t  access_q[$];
  rpb_pkg::out_item_t charge_q[$];

  // predictor copy of the wait-state registers and the ring
  logic [rpb_pkg::CfgRegW-1:0] ws0_cyc, ws1_cyc, ws2_cyc, sram_cyc;
  logic               pf_busy;
  logic [PtrW-1:0]    rd_ptr, wr_ptr;
  logic [3:0]         held;
  logic [8:0]         pf_count;
  logic [31:0]        slot_addr [rpb_pkg::BufferDepth];
  logic [31:0]        prev_fetch;
  logic [31:0]        last_rom;

  rom_prefetch_buffer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic cart_rom(input logic [31:0] a);
    return (a[31:24] >= rpb_pkg::RegionWs0Lo) && (a[31:24] <= rpb_pkg::RegionWs2Hi);
  endfunction

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (int'(p) + 1 >= rpb_pkg::BufferDepth) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [8:0] fetch_cycles(input logic [31:0] a, input logic th);
    logic [7:0] r;
    logic [8:0] s;
    r = a[31:24];
    if (r == rpb_pkg::RegionSramLo || r == rpb_pkg::RegionSramHi) return {5'd0, sram_cyc};
    if (r == rpb_pkg::RegionWs0Lo || r == rpb_pkg::RegionWs0Hi) s = {5'd0, ws0_cyc};
    else if (r == rpb_pkg::RegionWs1Lo || r == rpb_pkg::RegionWs1Hi) s = {5'd0, ws1_cyc};
    else if (r == rpb_pkg::RegionWs2Lo || r == rpb_pkg::RegionWs2Hi) s = {5'd0, ws2_cyc};
    else return 9'd1;
    return th ? s : (s << 1);
  endfunction

  task automatic predictor_reset();
    ws0_cyc = rpb_pkg::Ws0SeqReset;
    ws1_cyc = rpb_pkg::Ws1SeqReset;
    ws2_cyc = rpb_pkg::Ws2SeqReset;
    sram_cyc = rpb_pkg::SramReset;
    pf_busy = 1'b0;
    rd_ptr = '0;
    wr_ptr = '0;
    held = '0;
    pf_count = '0;
    for (int i = 0; i < rpb_pkg::BufferDepth; i++) slot_addr[i] = '0;
    prev_fetch = '0;
    last_rom = '0;
  endtask

  // One bus access: updates the ring state and returns the cycles charged.
  function automatic rpb_pkg::out_item_t predict_charge(input rpb_pkg::in_item_t acc);
    rpb_pkg::out_item_t res;
    logic [8:0]  cyc;
    logic [31:0] nxt;
    int unsigned cap;
    res = '0;
    cyc = {1'b0, acc.access_cycles};
    cap = acc.thumb_mode ? rpb_pkg::BufferDepth : rpb_pkg::BufferDepth / 2;
    if (pf_busy) begin
      if (acc.bus_address == slot_addr[wr_ptr]) begin
        // in-flight hit: wait out the rest of the fetch, entry consumed at once
        res.ticked_cycles = pf_count[7:0];
        res.buffer_hit = 1'b1;
        pf_busy = 1'b0;
        pf_count = '0;
        last_rom = acc.bus_address;
        return res;
      end
      if (cart_rom(acc.bus_address)) pf_busy = 1'b0;
    end else if (held < cap && cart_rom(acc.program_counter) &&
                 !cart_rom(acc.bus_address) && acc.program_counter == last_rom) begin
      nxt = (held != 0) ? prev_fetch : acc.program_counter;
      nxt = nxt + (acc.thumb_mode ? rpb_pkg::StepThumb : rpb_pkg::StepArm);
      prev_fetch = nxt;
      pf_busy = 1'b1;
      slot_addr[wr_ptr] = nxt;
      pf_count = fetch_cycles(nxt, acc.thumb_mode);
    end
    if (cart_rom(acc.bus_address)) last_rom = acc.bus_address;
    if (held != 0 && acc.bus_address == acc.program_counter) begin
      if (acc.bus_address == slot_addr[rd_ptr]) begin
        cyc = 9'd1;
        held = held - 1'b1;
        rd_ptr = ring_next(rd_ptr);
        res.buffer_hit = 1'b1;
      end else begin
        pf_busy = 1'b0;
        pf_count = '0;
        held = '0;
        rd_ptr = '0;
        wr_ptr = '0;
        res.buffer_flushed = 1'b1;
      end
    end
    if (pf_busy) begin
      if (cyc >= pf_count) begin
        pf_count = '0;
        if (held < rpb_pkg::BufferDepth) held = held + 1'b1;
        wr_ptr = ring_next(wr_ptr);
        pf_busy = 1'b0;
      end else begin
        pf_count = pf_count - cyc;
      end
    end
    res.ticked_cycles = cyc[7:0];
    return res;
  endfunction

  function automatic void flag_bad_charge(input string why, input rpb_pkg::out_item_t want,
                                          input rpb_pkg::out_item_t got);
    err_cnt++;
    if (err_cnt <= MaxReports)
      $display("%0t %s: want ticks %0d hit %0b flush %0b, got ticks %0d hit %0b flush %0b",
               $realtime, why, want.ticked_cycles, want.buffer_hit, want.buffer_flushed,
               got.ticked_cycles, got.buffer_hit, got.buffer_flushed);
  endfunction

  // driver
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) charge_q.push_back(predict_charge(in_item));
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (access_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        in_item <= access_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(negedge clk) begin
    out_ready <= rst_n && (calm || $urandom_range(0, 99) >= IdlePct);
  end

  always @(posedge clk) begin
    rpb_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (charge_q.size() == 0) begin
        flag_bad_charge("result with no pending transaction", '0, out_item);
      end else begin
        want = charge_q.pop_front();
        if (out_item.ticked_cycles !== want.ticked_cycles ||
            out_item.buffer_hit !== want.buffer_hit ||
            out_item.buffer_flushed !== want.buffer_flushed)
          flag_bad_charge("charge mismatch", want, out_item);
      end
    end
  end

  function automatic void push_access(input logic [31:0] a, input logic [7:0] c,
                                      input logic [31:0] p, input logic th);
    rpb_pkg::in_item_t it;
    it.bus_address = a;
    it.access_cycles = c;
    it.program_counter = p;
    it.thumb_mode = th;
    access_q.push_back(it);
    gen_cnt++;
  endfunction

  function automatic logic [7:0] small_cyc();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return 8'($urandom_range(1, 8));
    if (sel < 90) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] rand_rom_addr();
    logic [23:0] low;
    if ($urandom_range(0, 3) == 0) low = 24'hFFFFF0 | 24'($urandom_range(0, 15));
    else low = 24'($urandom);
    return {8'($urandom_range(8, 13)), low} & ~32'd1;
  endfunction

  function automatic logic [31:0] rand_other_addr();
    logic [7:0] hi;
    hi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(16, 255)) : 8'($urandom_range(0, 7));
    return {hi, 24'($urandom)};
  endfunction

  // Code running from cartridge: opcode fetches walk the program counter while
  // data accesses elsewhere give the unit time to prefetch.
  task automatic gen_cart_run(input int unsigned n);
    logic [31:0] cur;
    logic        th;
    int unsigned sel;
    th = 1'($urandom_range(0, 1));
    cur = rand_rom_addr();
    push_access(cur, small_cyc(), cur, th);
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        cur = cur + (th ? rpb_pkg::StepThumb : rpb_pkg::StepArm);
        push_access(cur, small_cyc(), cur, th);
      end else if (sel < 78) begin
        push_access(rand_other_addr(), small_cyc(), cur, th);
      end else if (sel < 83) begin
        push_access(rand_rom_addr(), small_cyc(), cur, th);
      end else if (sel < 88) begin
        cur = rand_rom_addr();
        push_access(cur, small_cyc(), cur, th);
      end else if (sel < 92) begin
        th = ~th;
      end else if (sel < 96) begin
        push_access({rpb_pkg::RegionSramLo | 8'($urandom_range(0, 1)), 24'($urandom)},
                    small_cyc(), cur, th);
      end else begin
        push_access(32'd0, 8'($urandom_range(0, 2)), cur, th);
      end
    end
  endtask

  task automatic gen_phase(input int unsigned n);
    int unsigned start;
    start = gen_cnt;
    while (gen_cnt - start < n) begin
      if ($urandom_range(0, 99) < 85) begin
        gen_cart_run($urandom_range(20, 60));
      end else begin
        repeat ($urandom_range(1, 5))
          push_access($urandom, 8'($urandom), $urandom, 1'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [rpb_pkg::CfgIdxW-1:0] idx,
                           input logic [rpb_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      rpb_pkg::RegWs0Seq: ws0_cyc = val[rpb_pkg::CfgRegW-1:0];
      rpb_pkg::RegWs1Seq: ws1_cyc = val[rpb_pkg::CfgRegW-1:0];
      rpb_pkg::RegWs2Seq: ws2_cyc = val[rpb_pkg::CfgRegW-1:0];
      rpb_pkg::RegSram:   sram_cyc = val[rpb_pkg::CfgRegW-1:0];
      default: ;
    endcase
  endtask

  // sender holds off until every transaction has come back
  task automatic drain();
    while (access_q.size() != 0 || in_valid || charge_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_waits(input logic [3:0] w0, input logic [3:0] w1,
                           input logic [3:0] w2, input logic [3:0] sr);
    drain();
    write_reg(rpb_pkg::RegWs0Seq, {4'($urandom), w0});
    write_reg(rpb_pkg::RegWs1Seq, {4'($urandom), w1});
    write_reg(rpb_pkg::RegWs2Seq, {4'($urandom), w2});
    write_reg(rpb_pkg::RegSram, {4'($urandom), sr});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [3:0] rand_wait();
    return 4'($urandom_range(1, 15));
  endfunction

  initial begin
    predictor_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, then each prefetch path at reset wait states
    push_access(32'd0, 8'd0, 32'd0, 1'b0);
    push_access(32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 1'b1);
    push_access(32'h0800_0100, 8'd3, 32'h0800_0100, 1'b1);
    push_access(32'h0300_0000, 8'd1, 32'h0800_0100, 1'b1);   // starts fetch
    push_access(32'h0800_0102, 8'd3, 32'h0800_0102, 1'b1);   // in-flight hit
    push_access(32'h0200_0000, 8'd5, 32'h0800_0102, 1'b1);
    push_access(32'h0400_0000, 8'd5, 32'h0800_0102, 1'b1);
    push_access(32'h0800_0104, 8'd3, 32'h0800_0104, 1'b1);   // served from ring
    push_access(32'h0800_0200, 8'd3, 32'h0800_0200, 1'b1);   // miss, flush
    push_access(32'h0A00_0000, 8'd4, 32'h0A00_0000, 1'b0);
    repeat (5) push_access(32'h0300_0040, 8'd255, 32'h0A00_0000, 1'b0); // fills ARM capacity
    push_access(32'h0300_0080, 8'd255, 32'h0A00_0000, 1'b1); // thumb: room again
    push_access(32'h0500_0000, 8'd1, 32'h0A00_0000, 1'b1);
    push_access(32'h0C00_0000, 8'd2, 32'h0A00_0000, 1'b1);   // ROM access aborts fetch
    push_access(32'h0DFF_FFFE, 8'd2, 32'h0DFF_FFFE, 1'b1);   // flush at top of ROM
    push_access(32'h0E00_0010, 8'd1, 32'h0DFF_FFFE, 1'b1);   // fetch into save memory
    push_access(32'h0E00_0000, 8'd7, 32'h0E00_0000, 1'b1);
    push_access(32'h0C00_0010, 8'd2, 32'h0C00_0010, 1'b0);
    push_access(32'h0300_0000, 8'd1, 32'h0C00_0010, 1'b0);
    push_access(32'h0600_0000, 8'd0, 32'h0C00_0010, 1'b0);   // zero cycles, no progress
    push_access(32'h0C00_0014, 8'd1, 32'h0C00_0014, 1'b0);

    set_waits(4'd15, 4'd15, 4'd15, 4'd15);
    gen_phase(190);
    set_waits(4'd1, 4'd1, 4'd1, 4'd1);
    calm = 1'b1;
    gen_phase(190);
    drain();
    calm = 1'b0;
    set_waits(rand_wait(), rand_wait(), rand_wait(), rand_wait());
    write_reg(8'($urandom_range(4, 255)), 8'($urandom));       // unmapped index
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_phase(190);
    set_waits(4'd15, 4'd1, rand_wait(), rand_wait());
    gen_phase(190);
    set_waits(rand_wait(), rand_wait(), rand_wait(), rand_wait());
    gen_phase(190);

    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && charge_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/rpb_pkg.sv
sv/rom_prefetch_buffer_core.sv
sv/rpb_checker.sv
bench/tb_top.sv
